>>> hw/rtl/dictionary_index_7bit_packer_defines.svh
// ----------------------------------------------------------------------------
// Dictionary index 7-bit packer - assertion macros
// Shared property checks, sampled on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef DICTIONARY_INDEX_7BIT_PACKER_DEFINES_SVH
`define DICTIONARY_INDEX_7BIT_PACKER_DEFINES_SVH

// same-cycle implication
`define DIP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// Dictionary index packer package
// Word types, request codes and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dip_pkg;

    localparam int CODE_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_EOS  = 2'd2;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hff;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CODE_W-1:0] entry_index;
        logic [BYTE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } res_word_t;

    typedef struct packed {
        logic       marker_pending;
        logic [2:0] phase;
    } bk_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dip_front.sv
// ----------------------------------------------------------------------------
// Dictionary index packer - front end
// Accepts command words, drops unused and out-of-range ones, queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dip_front
    import dip_pkg::*;
#(
    parameter int DICT_DEPTH = 128
)
(
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_word_t cmd_word,
    input  wire logic      q_full,
    output logic           q_push,
    output cmd_word_t      q_word
);

    localparam logic [CODE_W:0] IDX_LIM = (CODE_W+1)'(DICT_DEPTH);

    logic accepted;
    logic keep;

    always_comb
    begin
        case (cmd_word.req_type)
            REQ_LOAD: keep = ({1'b0, cmd_word.entry_index} < IDX_LIM);
            REQ_DATA: keep = 1'b1;
            REQ_EOS:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign cmd_stall = q_full;
    assign accepted  = cmd_valid && !q_full;
    assign q_push    = accepted && keep;
    assign q_word    = cmd_word;

endmodule

`default_nettype wire

>>> hw/rtl/dip_queue.sv
// ----------------------------------------------------------------------------
// Dictionary index packer - command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dip_queue
    import dip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cmd_word_t push_word,
    input  wire logic      pop,
    output logic           full,
    output logic           valid,
    output cmd_word_t      pop_word
);

    cmd_word_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QPTR_W:0]       count_reg;
    logic [QPTR_W:0]       count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_word = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dip_back.sv
// ----------------------------------------------------------------------------
// Dictionary index packer - back end
// Dictionary memory, sequential first-match scan, 7-bit code packing and
// the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dip_back
    import dip_pkg::*;
#(
    parameter int DICT_DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  dict_len,
    input  wire logic        q_valid,
    input  wire cmd_word_t   q_word,
    output logic             q_pop,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_word_t        res_word,
    output bk_stat_t         stat
);

    localparam int AW = $clog2(DICT_DEPTH);
    localparam int CW = $clog2(DICT_DEPTH + 1);
    localparam logic [7:0]    DEPTH_B = 8'(DICT_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DICT_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_PACK   = 3'd2;
    localparam logic [2:0] ST_EOS    = 3'd3;
    localparam logic [2:0] ST_MARK   = 3'd4;

    logic [BYTE_W-1:0] dict_mem [DICT_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [BYTE_W-1:0] val_reg;
    logic [BYTE_W-1:0] val_next;
    logic [CW-1:0]     addr_reg;
    logic [CW-1:0]     addr_next;
    logic              rd_vld_reg;
    logic              rd_vld_next;
    logic [AW-1:0]     rd_idx_reg;
    logic [AW-1:0]     rd_idx_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] last_index_reg;
    logic [CODE_W-1:0] last_index_next;
    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [BYTE_W-1:0] partial_reg;
    logic [BYTE_W-1:0] partial_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    res_word_t         out_word_reg;
    res_word_t         out_word_next;

    logic [CW-1:0]     lim;
    logic              out_free;
    logic              hit;
    logic              scan_end;
    logic              issue;
    logic              mem_we;
    logic              emit;
    res_word_t         emit_word;

    assign lim      = (dict_len > DEPTH_B) ? DEPTH_C : dict_len[CW-1:0];
    assign out_free = !out_vld_reg || !res_stall;
    assign hit      = rd_vld_reg && (rd_data_reg == val_reg);
    assign scan_end = (addr_reg == lim);
    assign issue    = (state_reg == ST_SEARCH) && !hit && !scan_end;

    always_comb
    begin
        state_next      = state_reg;
        val_next        = val_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = addr_reg[AW-1:0];
        code_next       = code_reg;
        last_index_next = last_index_reg;
        phase_next      = phase_reg;
        partial_next    = partial_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        emit            = 1'b0;
        emit_word       = '{out_byte: MARKER_BYTE, last: 1'b1};

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_word.req_type)
                        REQ_LOAD: mem_we = 1'b1;
                        REQ_DATA:
                        begin
                            val_next   = q_word.value;
                            addr_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        REQ_EOS:  state_next = ST_EOS;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                rd_vld_next = issue;
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (hit)
                begin
                    last_index_next = CODE_W'(rd_idx_reg);
                    code_next       = CODE_W'(rd_idx_reg);
                    state_next      = ST_PACK;
                end
                else if (scan_end)
                begin
                    code_next  = last_index_reg;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (phase_reg == 3'd0)
                begin
                    partial_next = {code_reg, 1'b0};
                    phase_next   = 3'd1;
                    state_next   = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = partial_reg | {1'b0, code_reg >> (3'd7 - phase_reg)};
                    emit_word.last     = 1'b1;
                    partial_next       = {code_reg, 1'b0} << phase_reg;
                    phase_next         = phase_reg + 3'd1;
                    state_next         = ST_IDLE;
                end
            end
            ST_EOS:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    phase_next   = 3'd0;
                    partial_next = '0;
                    if (phase_reg == 3'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_word.out_byte = partial_reg | ~(MARKER_BYTE << phase_reg);
                        emit_word.last     = (phase_reg == 3'd7);
                        state_next         = (phase_reg == 3'd7) ? ST_IDLE : ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        out_vld_next  = out_vld_reg;
        out_word_next = out_word_reg;
        if (emit)
        begin
            out_vld_next  = 1'b1;
            out_word_next = emit_word;
        end
        else if (!res_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_vld_reg     <= 1'b0;
            last_index_reg <= '0;
            phase_reg      <= '0;
            partial_reg    <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_vld_reg     <= rd_vld_next;
            last_index_reg <= last_index_next;
            phase_reg      <= phase_next;
            partial_reg    <= partial_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        code_reg     <= code_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dict_mem[q_word.entry_index[AW-1:0]] <= q_word.value;
        end
        rd_data_reg <= dict_mem[addr_reg[AW-1:0]];
    end

    assign res_valid           = out_vld_reg;
    assign res_word            = out_word_reg;
    assign stat.marker_pending = (state_reg == ST_MARK);
    assign stat.phase          = phase_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dictionary_index_7bit_packer.sv
// ----------------------------------------------------------------------------
// Dictionary index 7-bit packer - top level
// Replaces each data byte by its first-match dictionary index and packs the
// 7-bit codes MSB first into bytes, with end-of-stream padding and marker.
//
//   channel  direction  handshake             word
//   cmd      in         cmd_valid/cmd_stall   cmd_word_t (req_type, index, value)
//   res      out        res_valid/res_stall   res_word_t (out_byte, last)
//   cfg      in         dict_len_we           dict_len_wdata (dict_len)
//
// Load: a single dictionary memory write in the back end. Data byte: scanned
// one entry per cycle through the dictionary memory read port, up to
// min(dict_len, DICT_DEPTH) entries; a match ends the scan early.
// A two-deep queue lets cmd words enter while the back end scans or res stalls.
// Reset clears state and queue; the dictionary has no reset and no clear pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dictionary_index_7bit_packer_defines.svh"

module dictionary_index_7bit_packer
    import dip_pkg::*;
#(
    parameter int DICT_DEPTH = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire cmd_word_t  cmd_word,
    output logic            res_valid,
    input  wire logic       res_stall,
    output res_word_t       res_word,
    input  wire logic       dict_len_we,
    input  wire logic [7:0] dict_len_wdata
);

    logic [7:0] dict_len_reg;
    logic [7:0] dict_len_next;
    logic       q_full;
    logic       q_push;
    cmd_word_t  q_in_word;
    logic       q_valid;
    cmd_word_t  q_out_word;
    logic       q_pop;
    bk_stat_t   bk_stat;

    assign dict_len_next = dict_len_we ? dict_len_wdata : dict_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_len_reg <= '0;
        end
        else
        begin
            dict_len_reg <= dict_len_next;
        end
    end

    dip_front #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_word    (q_in_word)
    );

    dip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in_word),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .pop_word  (q_out_word)
    );

    dip_back #(
        .DICT_DEPTH (DICT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dict_len  (dict_len_reg),
        .q_valid   (q_valid),
        .q_word    (q_out_word),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .stat      (bk_stat)
    );

    `DIP_ASSERT_IMPL(a_full_stalls, q_full, cmd_stall, "queue full but cmd not stalled")
    `DIP_ASSERT_IMPL(a_pad_then_marker, res_valid && !res_word.last,
        bk_stat.marker_pending && (bk_stat.phase == 3'd0), "padded byte without marker pending")
    `DIP_ASSERT_NEXT(a_marker_follows, bk_stat.marker_pending && !res_stall,
        res_valid && res_word.last, "marker did not follow padded byte")

endmodule

`default_nettype wire

>>> tb/tb_dictionary_index_7bit_packer.sv
// ----------------------------------------------------------------------------
// Dictionary index 7-bit packer - regression testbench
// Starts with a short table of directed words, some with fixed results. Then
// come several dict_len settings, each with random streams of data bytes,
// reloads and end-of-stream words. Every result word is checked in order
// against a behavioral prediction or a fixed result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dictionary_index_7bit_packer;

    import dip_pkg::*;

    localparam int         DICT_DEPTH  = 128;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         N_ITEMS     = 950;
    localparam int         N_SETTINGS  = 8;
    localparam int         DRAIN_WAIT  = 3 * (DICT_DEPTH + 8);
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic       cfg;        // dict_len write; cmd.value carries the length
        cmd_word_t  cmd;
        logic       typed;      // results below are fixed, not predicted
        logic [1:0] n_res;
        res_word_t  r0;
        res_word_t  r1;
    } dir_row_t;

    localparam int N_DIR = 26;

    localparam res_word_t NO_RES   = '{8'h00, 1'b0};
    localparam res_word_t MARK_END = '{MARKER_BYTE, 1'b1};

    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{1'b0, '{REQ_UNUSED, 7'h7f, 8'hff}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h00, 8'h00}, 1'b1, 2'd1, MARK_END, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h7f, 8'hff}, 1'b1, 2'd1, '{8'h00, 1'b1}, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h7f, 8'hff}, 1'b1, 2'd2, '{8'h03, 1'b0}, MARK_END},
        '{1'b0, '{REQ_LOAD, 7'h00, 8'h00}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_LOAD, 7'h7f, 8'hff}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_LOAD, 7'h01, 8'h80}, 1'b1, 2'd0, NO_RES, NO_RES},
        '{1'b1, '{REQ_LOAD, 7'h00, 8'd2}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h55}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h80}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b1, '{REQ_LOAD, 7'h00, 8'd0}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_DATA, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES},
        '{1'b0, '{REQ_EOS, 7'h00, 8'h00}, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cmd_valid      = 1'b0;
    logic        cmd_stall;
    cmd_word_t   cmd_word       = '0;
    logic        res_valid;
    logic        res_stall      = 1'b0;
    res_word_t   res_word;
    logic        dict_len_we    = 1'b0;
    logic [7:0]  dict_len_wdata = 8'd0;

    // predicted block state
    logic [7:0]  dict_mem [DICT_DEPTH];
    bit          loaded   [DICT_DEPTH];
    logic [2:0]  code_phase   = 3'd0;
    logic [7:0]  pending_bits = 8'd0;
    logic [6:0]  last_code    = 7'd0;
    logic [7:0]  dict_len_cur = 8'd0;

    res_word_t   pending_bytes [$];
    int          n_items    = 0;
    int          n_bytes    = 0;
    int          n_errors   = 0;
    int          n_settings = 0;
    bit          tx_pauses  = 1'b1;
    bit          rx_pauses  = 1'b1;
    int          stall_left = 0;

    dictionary_index_7bit_packer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_word       (cmd_word),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_word       (res_word),
        .dict_len_we    (dict_len_we),
        .dict_len_wdata (dict_len_wdata)
    );

    always #4 clk = ~clk;

    function automatic int search_limit();
        return (dict_len_cur > DICT_DEPTH) ? DICT_DEPTH : int'(dict_len_cur);
    endfunction

    // advances the packing state by one word; keep = queue the bytes it makes
    task automatic pack_word(input cmd_word_t w, input bit keep);
        int          lim;
        bit          hit;
        logic [15:0] code_w;
        res_word_t   r;
        begin
            case (w.req_type)
                REQ_LOAD:
                begin
                    dict_mem[w.entry_index] = w.value;
                    loaded[w.entry_index]   = 1'b1;
                end
                REQ_DATA:
                begin
                    lim = search_limit();
                    hit = 1'b0;
                    for (int l = 0; l < lim; l++)
                    begin
                        if (!hit && dict_mem[l] == w.value)
                        begin
                            last_code = l[6:0];
                            hit       = 1'b1;
                        end
                    end
                    code_w = {9'd0, last_code};
                    if (code_phase == 3'd0)
                    begin
                        pending_bits = {last_code, 1'b0};
                    end
                    else
                    begin
                        r.out_byte = pending_bits | 8'(code_w >> (7 - code_phase));
                        r.last     = 1'b1;
                        if (keep)
                            pending_bytes.push_back(r);
                        pending_bits = (code_phase == 3'd7) ? 8'd0
                                     : 8'(code_w << (code_phase + 1));
                    end
                    code_phase = code_phase + 3'd1;
                end
                REQ_EOS:
                begin
                    if (code_phase == 3'd0)
                    begin
                        if (keep)
                            pending_bytes.push_back('{MARKER_BYTE, 1'b1});
                    end
                    else
                    begin
                        r.out_byte = pending_bits | 8'((16'd1 << code_phase) - 16'd1);
                        r.last     = (code_phase == 3'd7);
                        if (keep)
                            pending_bytes.push_back(r);
                        if (keep && code_phase != 3'd7)
                            pending_bytes.push_back('{MARKER_BYTE, 1'b1});
                    end
                    code_phase   = 3'd0;
                    pending_bits = 8'd0;
                end
                default: ;
            endcase
        end
    endtask

    // called at a clock edge; returns at the edge the word is taken
    task automatic send_word(input cmd_word_t w, input bit keep);
        int gap;
        begin
            if ($urandom_range(0, 31) == 0)
                tx_pauses = ~tx_pauses;
            gap = tx_pauses ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cmd_valid <= 1'b1;
            cmd_word  <= w;
            @(posedge clk);
            while (cmd_stall)
                @(posedge clk);
            if (w.req_type != REQ_UNUSED)
                n_items++;
            pack_word(w, keep);
        end
    endtask

    task automatic wait_idle();
        begin
            cmd_valid <= 1'b0;
            while (pending_bytes.size() != 0)
                @(posedge clk);
            repeat (DRAIN_WAIT) @(posedge clk);
        end
    endtask

    task automatic write_dict_len(input logic [7:0] len);
        begin
            wait_idle();
            dict_len_we    <= 1'b1;
            dict_len_wdata <= len;
            @(posedge clk);
            dict_len_we    <= 1'b0;
            dict_len_cur   = len;
            n_settings++;
        end
    endtask

    // loads distinct symbols so that every index can be the first match
    task automatic fill_dict(input bit fresh);
        logic [7:0] base;
        logic [7:0] step;
        begin
            base = 8'($urandom);
            step = 8'($urandom) | 8'h01;
            for (int i = 0; i < DICT_DEPTH; i++)
            begin
                if (fresh || (i < search_limit() && !loaded[i]))
                    send_word('{REQ_LOAD, 7'(i), 8'(i * step + base)}, 1'b1);
            end
        end
    endtask

    function automatic logic [7:0] pick_symbol();
        int lim;
        begin
            lim = search_limit();
            if (lim > 0 && $urandom_range(0, 3) != 0)
                return dict_mem[$urandom_range(0, lim - 1)];
            if ($urandom_range(0, 1) == 0)
                return dict_mem[$urandom_range(0, DICT_DEPTH - 1)];
            return 8'($urandom);
        end
    endfunction

    task automatic run_stream();
        int len;
        int roll;
        begin
            len = $urandom_range(0, 20);
            for (int k = 0; k < len; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    send_word('{REQ_LOAD, 7'($urandom), 8'($urandom)}, 1'b1);
                else if (roll < 9)
                    send_word('{REQ_UNUSED, 7'($urandom), 8'($urandom)}, 1'b1);
                else
                    send_word('{REQ_DATA, 7'($urandom), pick_symbol()}, 1'b1);
            end
            send_word('{REQ_EOS, 7'($urandom), 8'($urandom)}, 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            n_bytes++;
            if (pending_bytes.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: unexpected word byte=%h last=%b",
                             res_word.out_byte, res_word.last);
            end
            else if (res_word.out_byte !== pending_bytes[0].out_byte
                     || res_word.last !== pending_bytes[0].last)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: word %0d exp byte=%h last=%b got byte=%h last=%b",
                             n_bytes, pending_bytes[0].out_byte, pending_bytes[0].last,
                             res_word.out_byte, res_word.last);
                void'(pending_bytes.pop_front());
            end
            else
            begin
                void'(pending_bytes.pop_front());
            end
            if ($urandom_range(0, 29) == 0)
                rx_pauses = ~rx_pauses;
            stall_left = rx_pauses ? $urandom_range(0, 7) : 0;
        end
        if (stall_left != 0)
        begin
            res_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    initial
    begin
        #8_000_000;
        $display("dictionary_index_7bit_packer regression: fail");
        $finish;
    end

    initial
    begin
        logic [7:0] len_list [N_SETTINGS];
        int         target;

        len_list = '{8'd128, 8'd255, 8'd1, 8'd0, 8'd127, 8'd2, 8'd64, 8'd128};
        len_list[6] = 8'($urandom_range(3, 126));
        for (int i = 0; i < DICT_DEPTH; i++)
        begin
            dict_mem[i] = 8'd0;
            loaded[i]   = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIR_TAB[i].cfg)
            begin
                write_dict_len(DIR_TAB[i].cmd.value);
            end
            else
            begin
                send_word(DIR_TAB[i].cmd, !DIR_TAB[i].typed);
                if (DIR_TAB[i].typed && DIR_TAB[i].n_res > 0)
                    pending_bytes.push_back(DIR_TAB[i].r0);
                if (DIR_TAB[i].typed && DIR_TAB[i].n_res > 1)
                    pending_bytes.push_back(DIR_TAB[i].r1);
            end
        end

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            write_dict_len(len_list[s]);
            fill_dict(search_limit() == DICT_DEPTH);
            target = N_DIR + (s + 1) * N_ITEMS / N_SETTINGS;
            while (n_items < target)
                run_stream();
        end

        wait_idle();
        $display("Checked %0d result words from %0d input words over %0d dict_len settings",
                 n_bytes, n_items, n_settings);
        $display("(loads, data bytes at every code phase, end of stream, unused requests).");
        if (n_errors == 0 && pending_bytes.size() == 0)
            $display("dictionary_index_7bit_packer regression: pass");
        else
            $display("dictionary_index_7bit_packer regression: fail");
        $finish;
    end

endmodule
